>>> rtl/hvq_pkg.sv
// Shared types, constants and helper functions for the half vector to quaternion block.
// Depends on nothing; every rtl file imports it.
package hvq_pkg;

  localparam logic [31:0] SGL_QUIET = 32'h0040_0000;
  localparam logic [31:0] SGL_ONE   = 32'h3F80_0000;
  localparam logic [7:0]  SGL_EXP_ALL = 8'hFF;
  localparam logic [7:0]  SGL_BIAS    = 8'd127;
  localparam logic [4:0]  HALF_EXP_ALL = 5'h1F;
  localparam logic [7:0]  HALF_REBIAS  = 8'd112;
  localparam logic [7:0]  SUBN_BASE    = 8'd103;
  localparam int unsigned ROOT_STEPS = 25;
  localparam logic [4:0]  ROOT_LAST  = 5'(ROOT_STEPS - 1);

  typedef struct packed {
    logic [15:0] x_half;
    logic [15:0] y_half;
    logic [15:0] z_half;
  } req_t;

  typedef struct packed {
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    logic [31:0] qw;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ADD1, S_ADD2, S_DIFF, S_NORM, S_ROOT, S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic add_first;
    logic add_second;
    logic diff;
    logic norm_step;
    logic root_init;
    logic root_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic w_ready;
    logic norm_ok;
    logic root_last;
    logic out_free;
  } sts_t;

  // Exact widening of a half-precision pattern to single precision.
  function automatic logic [31:0] widen(input logic [15:0] h);
    logic       sg;
    logic [4:0] ex;
    logic [9:0] fr;
    logic [3:0] p;
    logic [10:0] sh;
    logic [31:0] r;
    sg = h[15];
    ex = h[14:10];
    fr = h[9:0];
    p  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) p = 4'(i);
    end
    sh = 11'({1'b0, fr} << (4'd10 - p));
    if (ex == 5'd0) begin
      if (fr == 10'd0) r = {sg, 31'd0};
      else r = {sg, SUBN_BASE + {4'd0, p}, sh[9:0], 13'd0};
    end else if (ex == HALF_EXP_ALL) begin
      r = {sg, SGL_EXP_ALL, fr, 13'd0};
    end else begin
      r = {sg, {3'd0, ex} + HALF_REBIAS, fr, 13'd0};
    end
    return r;
  endfunction

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == SGL_EXP_ALL) && (b[22:0] != 23'd0);
  endfunction

endpackage

>>> rtl/hvq_ctrl.sv
// Sequencer for the half vector to quaternion block.
// Depends on hvq_pkg; drives commands into hvq_dpath and reads its status.
module hvq_ctrl
  import hvq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign src_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (src_valid) begin
          cmd.load = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = sts.w_ready ? S_FIN : S_ADD1;
      end
      S_ADD1: begin
        cmd.add_first = 1'b1;
        state_next = S_ADD2;
      end
      S_ADD2: begin
        cmd.add_second = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.w_ready) state_next = S_FIN;
        else if (sts.norm_ok) begin
          cmd.root_init = 1'b1;
          state_next = S_ROOT;
        end else cmd.norm_step = 1'b1;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/hvq_dpath.sv
// Datapath: widening, squares, rounded sum, 1 - s, bit-pair square root, result register.
// Depends on hvq_pkg; steered by hvq_ctrl.
module hvq_dpath
  import hvq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  req_t src_data,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic dst_stall,
  output logic dst_valid,
  output rsp_t dst_data
);

  logic [31:0] c [3];
  logic        w_ready;
  logic [31:0] w;
  logic [23:0] sq_m [3];
  logic signed [7:0] sq_e [3];
  logic        sq_z [3];
  logic [23:0] acc_m;
  logic signed [7:0] acc_e;
  logic        acc_z;
  logic [23:0] nrm;
  logic [3:0]  shcnt;
  logic [26:0] rem;
  logic [24:0] root;
  logic [49:0] opnd;
  logic [4:0]  cnt;

  // load-time decode
  logic [31:0] wc [3];
  logic        nan_any, big_any;
  logic [31:0] w_load;
  always_comb begin
    wc[0] = widen(src_data.x_half);
    wc[1] = widen(src_data.y_half);
    wc[2] = widen(src_data.z_half);
    nan_any = is_nan(wc[0]) | is_nan(wc[1]) | is_nan(wc[2]);
    // any component of magnitude one or more drives the sum to at least one
    big_any = (wc[0][30:23] >= SGL_BIAS) | (wc[1][30:23] >= SGL_BIAS) |
              (wc[2][30:23] >= SGL_BIAS);
    if (is_nan(wc[0])) w_load = wc[0] | SGL_QUIET;
    else if (is_nan(wc[1])) w_load = wc[1] | SGL_QUIET;
    else if (is_nan(wc[2])) w_load = wc[2] | SGL_QUIET;
    else w_load = 32'd0;
  end

  // squares
  logic [21:0] prod [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {1'b1, c[i][22:13]} * {1'b1, c[i][22:13]};
    end
  end

  // rounded add of two non-negative values
  logic [23:0] a_m, b_m, bg_m, sm_m, add_m;
  logic signed [7:0] a_e, b_e, bg_e, sm_e, add_e, dd;
  logic        a_z, b_z, add_z;
  logic [4:0]  dcl;
  logic [49:0] sb;
  logic [50:0] ssum;
  logic [23:0] rm;
  logic        rb, rs, inc;
  logic [24:0] rmi;
  always_comb begin
    a_m = cmd.add_first ? sq_m[0] : acc_m;
    a_e = cmd.add_first ? sq_e[0] : acc_e;
    a_z = cmd.add_first ? sq_z[0] : acc_z;
    b_m = cmd.add_first ? sq_m[1] : sq_m[2];
    b_e = cmd.add_first ? sq_e[1] : sq_e[2];
    b_z = cmd.add_first ? sq_z[1] : sq_z[2];
    if (a_e >= b_e) begin
      bg_m = a_m; bg_e = a_e; sm_m = b_m; sm_e = b_e;
    end else begin
      bg_m = b_m; bg_e = b_e; sm_m = a_m; sm_e = a_e;
    end
    dd   = bg_e - sm_e;
    // beyond 26 places the smaller operand only acts as sticky
    dcl  = (dd > 8'sd26) ? 5'd26 : dd[4:0];
    sb   = {sm_m, 26'd0} >> dcl;
    ssum = {1'b0, bg_m, 26'd0} + {1'b0, sb};
    if (ssum[50]) begin
      rm = ssum[50:27]; rb = ssum[26]; rs = |ssum[25:0];
    end else begin
      rm = ssum[49:26]; rb = ssum[25]; rs = |ssum[24:0];
    end
    inc = rb & (rs | rm[0]);
    rmi = {1'b0, rm} + {24'd0, inc};
    add_e = bg_e + {7'd0, ssum[50]} + {7'd0, rmi[24]};
    add_m = rmi[24] ? 24'h80_0000 : rmi[23:0];
    add_z = 1'b0;
    if (b_z) begin
      add_m = a_m; add_e = a_e; add_z = a_z;
    end else if (a_z) begin
      add_m = b_m; add_e = b_e; add_z = 1'b0;
    end
  end

  // 1 - s in units of 2^-24
  logic [24:0] nval, base;
  logic [7:0]  shw;
  logic [48:0] wide;
  always_comb begin
    shw  = 8'(-acc_e - 8'sd1);
    wide = {acc_m, 25'd0} >> shw[5:0];
    base = 25'h100_0000 - {1'b0, wide[48:25]};
    if (acc_z) nval = 25'h100_0000;
    else if (acc_e >= 8'sd0) nval = 25'd0;
    else if (acc_e == -8'sd1) nval = 25'h100_0000 - {1'b0, acc_m};
    else if (wide[24] && (wide[23:0] != 24'd0)) nval = base - 25'd1;
    else if (wide[24]) nval = base[0] ? base - 25'd1 : base;
    else nval = base;
  end

  // one root digit
  logic [28:0] cur, trial;
  always_comb begin
    cur   = {rem, opnd[49:48]};
    trial = {2'd0, root, 2'b01};
  end

  // result packing
  logic [24:0] q;
  logic [7:0]  qexp;
  logic [31:0] qw;
  always_comb begin
    q    = {1'b0, root[24:1]} + {24'd0, root[0]};
    qexp = q[24] ? (SGL_BIAS - {4'd0, shcnt}) : (SGL_BIAS - 8'd1 - {4'd0, shcnt});
    qw   = w_ready ? w : {1'b0, qexp, q[24] ? 23'd0 : q[22:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) c[i] <= wc[i];
      w_ready <= nan_any | big_any;
      w <= w_load;
    end
    if (cmd.square) begin
      for (int i = 0; i < 3; i++) begin
        sq_z[i] <= (c[i][30:23] == 8'd0);
        sq_m[i] <= prod[i][21] ? {prod[i], 2'd0} : {prod[i][20:0], 3'd0};
        sq_e[i] <= 8'($signed({2'd0, c[i][30:23], 1'b0}) - 11'sd254
                      + {10'd0, prod[i][21]});
      end
    end
    if (cmd.add_first || cmd.add_second) begin
      acc_m <= add_m; acc_e <= add_e; acc_z <= add_z;
    end
    if (cmd.diff) begin
      nrm   <= nval[23:0];
      shcnt <= 4'd0;
      if (nval == 25'd0) begin
        w_ready <= 1'b1; w <= 32'd0;
      end else if (nval[24]) begin
        w_ready <= 1'b1; w <= SGL_ONE;
      end
    end
    if (cmd.norm_step) begin
      nrm   <= nrm << 2;
      shcnt <= shcnt + 4'd1;
    end
    if (cmd.root_init) begin
      opnd <= {nrm, 26'd0};
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end
    if (cmd.root_step) begin
      opnd <= opnd << 2;
      cnt  <= cnt + 5'd1;
      if (cur >= trial) begin
        rem  <= 27'(cur - trial);
        root <= {root[23:0], 1'b1};
      end else begin
        rem  <= cur[26:0];
        root <= {root[23:0], 1'b0};
      end
    end
    if (cmd.finish) dst_data <= '{qx: c[0], qy: c[1], qz: c[2], qw: qw};
  end

  always_ff @(posedge clk) begin
    if (rst) dst_valid <= 1'b0;
    else if (cmd.finish) dst_valid <= 1'b1;
    else if (!dst_stall) dst_valid <= 1'b0;
  end

  assign sts.w_ready   = w_ready;
  assign sts.norm_ok   = nrm[23:22] != 2'd0;
  assign sts.root_last = (cnt == ROOT_LAST);
  assign sts.out_free  = !dst_valid || !dst_stall;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!dst_valid || !dst_stall)) else $error("result overwritten");
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.norm_step |-> (nrm != 24'd0) && (shcnt < 4'd12)) else $error("bad normalize");
  a_root_count: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |-> (cnt <= ROOT_LAST)) else $error("root overrun");
  a_root_normed: assert property (@(posedge clk) disable iff (rst)
    cmd.root_init |-> (nrm[23:22] != 2'd0)) else $error("root of unnormalized value");

endmodule

>>> rtl/half_vector_to_quaternion.sv
// Top level: half-precision vector components in, single-precision quaternion out.
// Depends on hvq_pkg, hvq_ctrl and hvq_dpath.
//
//  channel | direction | handshake            | payload
//  src     | in        | src_valid/src_stall  | req_t {x_half, y_half, z_half}
//  dst     | out       | dst_valid/dst_stall  | rsp_t {qx, qy, qz, qw}
//
// One item at a time. After squaring, the result is packed at once when a NaN or
// a component of magnitude one or more settles w at load; otherwise the two adds
// and the 1 - s step follow, and the result is packed when 1 - s is exactly zero
// or one. Else n (0 to 11) two-bit normalize shifts and the 25-step bit-pair
// square root loop run before packing. The sequencer then returns to idle,
// where the next transfer is taken.
// rst is synchronous and clears the sequencer and the result valid flag.
// A new item is taken while the previous result waits in the output register;
// the final cycle holds only while that register is still occupied.
module half_vector_to_quaternion
  import hvq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  req_t src_data,
  output logic dst_valid,
  input  logic dst_stall,
  output rsp_t dst_data
);

  cmd_t cmd;
  sts_t sts;

  // sequence the square, sum, difference and root steps
  hvq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and result register
  hvq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .src_data  (src_data),
    .cmd       (cmd),
    .sts       (sts),
    .dst_stall (dst_stall),
    .dst_valid (dst_valid),
    .dst_data  (dst_data)
  );

endmodule
